### hdl/max_pool_3x3_stride2_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 3x3 stride-2 max pooling block.
// Shared property forms used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef MAX_POOL_3X3_STRIDE2_ASSERT_SVH
`define MAX_POOL_3X3_STRIDE2_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent, also across reset.
`define MP3S2_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("max_pool_3x3_stride2: next-cycle check failed");

// The consequent must hold in the same cycle, ignored during reset.
`define MP3S2_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("max_pool_3x3_stride2: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent, ignored during reset.
`define MP3S2_ASSERT_NEXT_RST(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("max_pool_3x3_stride2: next-cycle check failed");

`endif

### hdl/mp3s2_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Max pooling package
// Sizes, item types, register codes and the signed maximum helper.
// ---------------------------------------------------------------------------
package mp3s2_pkg;

   // Sample and line store sizes.
   localparam int SAMPLE_BITS    = 16;
   localparam int MAX_WIDTH      = 256;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int PART_DEPTH     = MAX_WIDTH / 2;
   localparam int PART_ADDR_BITS = $clog2(PART_DEPTH);

   // Configuration register widths.
   localparam int HEIGHT_BITS    = 11;
   localparam int WIDTH_BITS     = 9;
   localparam int CHAN_BITS      = 11;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_HEIGHT    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_WIDTH     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // Reset values of the registers.
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 11'd112;
   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 9'd112;
   localparam logic [CHAN_BITS-1:0]   CHAN_RESET   = 11'd1;

   // Queue sizes.
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // Work handed from the front part to the back part: one closed column group.
   typedef struct packed {
      sample_type                hmax;
      logic [PART_ADDR_BITS-1:0] ox;
      logic                      row_odd;
      logic                      row_zero;
      logic                      last_row;
      logic                      eom;
      logic                      eoa;
   } job_type;

   // One result item.
   typedef struct packed {
      sample_type pooled;
      logic       eom;
      logic       eoa;
   } rsp_type;

   function automatic sample_type smax(input sample_type a, input sample_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

### hdl/mp3s2_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Max pooling front part
// Holds the configuration and the map position, accepts samples, forms the
// horizontal window maximum and hands closed column groups to the back part.
// ---------------------------------------------------------------------------
module mp3s2_front
   import mp3s2_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_push,
   input  sample_type                req_sample,
   input  logic                      q_full,
   output logic                      job_push,
   output job_type                   job
);

   logic [HEIGHT_BITS-1:0] height_ff, height_in;
   logic [WIDTH_BITS-1:0]  width_ff, width_in;
   logic [CHAN_BITS-1:0]   chan_cnt_ff, chan_cnt_in;
   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [HEIGHT_BITS-1:0] row_ff, row_in;
   logic [CHAN_BITS-1:0]   chan_ff, chan_in;
   sample_type             rrm_ff, rrm_in;

   logic [HEIGHT_BITS-1:0] h_eff;
   logic [WIDTH_BITS-1:0]  w_eff;
   logic [CHAN_BITS-1:0]   ch_eff;
   logic                   accept;
   logic                   last_col, last_row, last_ch;
   logic                   col_odd, col_close;
   sample_type             h_even, hmax;

   // Configuration writes; an unknown index is ignored.
   always_comb begin
      height_in   = height_ff;
      width_in    = width_ff;
      chan_cnt_in = chan_cnt_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_HEIGHT:    height_in   = csr_wdata[HEIGHT_BITS-1:0];
            CSR_MAP_WIDTH:     width_in    = csr_wdata[WIDTH_BITS-1:0];
            CSR_CHANNEL_COUNT: chan_cnt_in = csr_wdata[CHAN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective sizes: zero acts as one, the width is capped at the line store.
   always_comb begin
      h_eff  = (height_ff == '0) ? HEIGHT_BITS'(1) : height_ff;
      ch_eff = (chan_cnt_ff == '0) ? CHAN_BITS'(1) : chan_cnt_ff;
      priority if (width_ff == '0) begin
         w_eff = WIDTH_BITS'(1);
      end else if (width_ff > WIDTH_BITS'(MAX_WIDTH)) begin
         w_eff = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
   end

   // Position flags; an index past a shrunken size counts as the last one.
   assign accept   = req_push && !q_full;
   assign last_col = (WIDTH_BITS'(col_ff) + WIDTH_BITS'(1)) >= w_eff;
   assign last_row = ({1'b0, row_ff} + (HEIGHT_BITS + 1)'(1)) >= {1'b0, h_eff};
   assign last_ch  = ({1'b0, chan_ff} + (CHAN_BITS + 1)'(1)) >= {1'b0, ch_eff};
   assign col_odd  = col_ff[0];
   assign col_close = col_odd || last_col;

   // Horizontal window maximum, with the padding column on both map edges.
   always_comb begin
      h_even = (col_ff == '0) ? smax('0, req_sample) : smax(rrm_ff, req_sample);
      if (col_odd) begin
         hmax   = smax(rrm_ff, req_sample);
         rrm_in = req_sample;
      end else begin
         rrm_in = h_even;
         hmax   = last_col ? smax(h_even, '0) : h_even;
      end
   end

   // Position advance in raster order, channel after channel.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      chan_in = chan_ff;
      if (last_col) begin
         col_in = '0;
         if (last_row) begin
            row_in  = '0;
            chan_in = last_ch ? '0 : chan_ff + CHAN_BITS'(1);
         end else begin
            row_in = row_ff + HEIGHT_BITS'(1);
         end
      end else begin
         col_in = col_ff + COL_BITS'(1);
      end
   end

   // Job for the back part.
   always_comb begin
      job.hmax     = hmax;
      job.ox       = col_ff[COL_BITS-1:1];
      job.row_odd  = row_ff[0];
      job.row_zero = (row_ff == '0);
      job.last_row = last_row;
      job.eom      = last_row && last_col;
      job.eoa      = last_row && last_col && last_ch;
   end

   assign job_push = accept && col_close;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff   <= HEIGHT_RESET;
         width_ff    <= WIDTH_RESET;
         chan_cnt_ff <= CHAN_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         chan_ff     <= '0;
         rrm_ff      <= '0;
      end else begin
         height_ff   <= height_in;
         width_ff    <= width_in;
         chan_cnt_ff <= chan_cnt_in;
         if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            chan_ff <= chan_in;
            rrm_ff  <= rrm_in;
         end
      end
   end

endmodule

### hdl/mp3s2_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Max pooling job queue
// Short queue of column group jobs between the front and back parts.
// ---------------------------------------------------------------------------
module mp3s2_queue
   import mp3s2_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    valid,
   output logic    full,
   output job_type head_job
);

   job_type                entry_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]  wr_ff, wr_in;
   logic [Q_PTR_BITS-1:0]  rd_ff, rd_in;
   logic [Q_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign valid    = (cnt_ff != '0);
   assign full     = (cnt_ff == Q_CNT_BITS'(Q_DEPTH));
   assign head_job = entry_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // Pointer and fill count update.
   always_comb begin
      wr_in  = do_push ? wr_ff + Q_PTR_BITS'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + Q_PTR_BITS'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + Q_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - Q_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

### hdl/mp3s2_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Max pooling back part
// Keeps the partial vertical maxima per output column, closes windows and
// queues result items for the receiver.
// ---------------------------------------------------------------------------
module mp3s2_back
   import mp3s2_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  job_type q_head,
   output logic    q_pop,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp
);

   // Partial vertical maximum for each output column.
   sample_type part_mem [PART_DEPTH];

   job_type               b_job_ff;
   logic                  b_valid_ff, b_valid_in;
   sample_type            rd_data_ff;
   logic                  fwd_ff;
   sample_type            fwd_data_ff;

   rsp_type               out_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] out_wr_ff, out_wr_in;
   logic [Q_PTR_BITS-1:0] out_rd_ff, out_rd_in;
   logic [Q_CNT_BITS-1:0] out_cnt_ff, out_cnt_in;

   sample_type            part, base, result, wdata;
   logic                  b_emit, b_go, out_ready, out_push, out_pop;
   rsp_type               out_item;

   // Window close: combine the stored partial maximum with this row group.
   always_comb begin
      part = fwd_ff ? fwd_data_ff : rd_data_ff;
      base = b_job_ff.row_zero ? smax('0, b_job_ff.hmax) : smax(part, b_job_ff.hmax);
      if (b_job_ff.row_odd) begin
         result = smax(part, b_job_ff.hmax);
         wdata  = b_job_ff.hmax;
      end else begin
         result = smax(base, '0);
         wdata  = base;
      end
   end

   // Stage control: the stage moves on unless its result finds no room.
   assign b_emit    = b_job_ff.row_odd || b_job_ff.last_row;
   assign out_ready = (out_cnt_ff != Q_CNT_BITS'(Q_DEPTH));
   assign b_go      = b_valid_ff && (!b_emit || out_ready);
   assign q_pop     = q_valid && (!b_valid_ff || b_go);
   assign out_push  = b_go && b_emit;
   assign out_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (q_pop) begin
         b_valid_in = 1'b1;
      end else if (b_go) begin
         b_valid_in = 1'b0;
      end
   end

   // Memory read on stage entry, write when the stage moves on. A write to the
   // column read in the same cycle is forwarded, as the read sees old data.
   always_ff @(posedge clock) begin
      if (b_go) begin
         part_mem[b_job_ff.ox] <= wdata;
      end
      if (q_pop) begin
         rd_data_ff  <= part_mem[q_head.ox];
         fwd_data_ff <= wdata;
         b_job_ff    <= q_head;
      end
   end

   // Result queue.
   always_comb begin
      out_item.pooled = result;
      out_item.eom    = b_job_ff.eom;
      out_item.eoa    = b_job_ff.eoa;
      out_wr_in  = out_push ? out_wr_ff + Q_PTR_BITS'(1) : out_wr_ff;
      out_rd_in  = out_pop ? out_rd_ff + Q_PTR_BITS'(1) : out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + Q_CNT_BITS'(1);
      end else if (out_pop && !out_push) begin
         out_cnt_in = out_cnt_ff - Q_CNT_BITS'(1);
      end
   end

   assign rsp_empty = (out_cnt_ff == '0);
   assign rsp       = out_ff[out_rd_ff];

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_ff[out_wr_ff] <= out_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (q_pop) begin
            fwd_ff <= b_go && (b_job_ff.ox == q_head.ox);
         end
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

endmodule

### hdl/max_pool_3x3_stride2.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// 3x3 stride-2 max pooling, one ring of zero padding
// Streams channel maps in raster order and emits one window maximum per
// output position, with end-of-map and end-of-all flags.
// ---------------------------------------------------------------------------
// Usage:
//   Input: samples enter on req_sample; an item is taken when req_push is high
//   and req_full is low. Results: while rsp_empty is low the oldest result is
//   on rsp_pooled, rsp_end_of_map and rsp_end_of_all; rsp_pop takes it.
//   Configuration: csr_we writes csr_wdata into register csr_index (0 height,
//   1 width, 2 channel count) at once; write only while the block is idle.
//   Throughput: one sample per cycle while req_full is low. Each window closes on the sample that
//   completes it, so results come at most one per sample.
//   Result path: the job of a closing sample passes the job queue and the
//   partial-max memory read stage before its result enters the result queue.
//   Reset: synchronous; both queues empty, the position returns to the first
//   sample of the first channel and the registers return to 112 x 112 x 1.
//   No clearing pass is needed; the partial-max memory is written before use.
//   Receiver stall: results collect in a four-entry queue; when it fills, the
//   back part halts, the job queue fills and req_full rises.
// ---------------------------------------------------------------------------
module max_pool_3x3_stride2
   import mp3s2_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      req_push,
   output logic                      req_full,
   input  sample_type                req_sample,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output sample_type                rsp_pooled,
   output logic                      rsp_end_of_map,
   output logic                      rsp_end_of_all
);

   logic    job_push, q_full, q_valid, q_pop;
   job_type job, q_head;
   rsp_type rsp;

   // Front part: configuration, position and horizontal maximum.
   mp3s2_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_push   (req_push),
      .req_sample (req_sample),
      .q_full     (q_full),
      .job_push   (job_push),
      .job        (job)
   );

   // Job queue between the two parts.
   mp3s2_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (q_pop),
      .valid    (q_valid),
      .full     (q_full),
      .head_job (q_head)
   );

   // Back part: vertical maximum and result queue.
   mp3s2_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign req_full       = q_full;
   assign rsp_pooled     = rsp.pooled;
   assign rsp_end_of_map = rsp.eom;
   assign rsp_end_of_all = rsp.eoa;

endmodule

### hdl/mp3s2_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Max pooling port checker
// Watches the top level ports and checks reset behavior, result flags and result holding.
// ---------------------------------------------------------------------------
`include "max_pool_3x3_stride2_assert.svh"

module mp3s2_checker
   import mp3s2_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_full,
   input logic                      rsp_empty,
   input logic                      rsp_pop,
   input sample_type                rsp_pooled,
   input logic                      rsp_end_of_map,
   input logic                      rsp_end_of_all
);

   // After reset no result is waiting and the input side is open.
   `MP3S2_ASSERT_NEXT(a_reset_empty, clock, reset, rsp_empty)
   `MP3S2_ASSERT_NEXT(a_reset_open, clock, reset, !req_full)

   // The last result of all channels is also the last of its map.
   `MP3S2_ASSERT_IMPL(a_eoa_in_eom, clock, reset, !rsp_empty && rsp_end_of_all, rsp_end_of_map)

   // A waiting result that is not taken stays put.
   `MP3S2_ASSERT_NEXT_RST(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_pooled))

endmodule

bind max_pool_3x3_stride2 mp3s2_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_pooled     (rsp_pooled),
   .rsp_end_of_map (rsp_end_of_map),
   .rsp_end_of_all (rsp_end_of_all)
);
